@@ src/assert_macros.svh @@
// Assertion macros shared by the flash region registry modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, once seen, forces another one in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/frr_pkg.sv @@
// Types and constants shared by the flash region registry modules.
package frr_pkg;

  localparam int ADDR_W      = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [ADDR_W-1:0] ID_BYTES        = 32'd1;
  localparam logic [ADDR_W-1:0] SECTOR_SIZE_RST = 32'd131072;

  // Configuration register indexes.
  localparam logic CFG_SECTOR_BASE = 1'b0;
  localparam logic CFG_SECTOR_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_APPEND   = 2'd1,
    OP_READ     = 2'd2,
    OP_RELEASE  = 2'd3
  } opcode_t;

  // One table entry as held in the segment RAM.
  typedef struct packed {
    logic [ADDR_W-1:0] used;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic scan_rd;
    logic lookup_rd;
    logic finish_reg;
    logic finish_op;
    logic out_load;
  } frr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_register;
    logic scan_last;
  } frr_stat_t;

endpackage

@@ src/frr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module frr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/frr_datapath.sv @@
// Datapath: configuration, segment table, overlap scan and result registers.
`include "assert_macros.svh"

module frr_datapath
  import frr_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  frr_cmd_t               cmd,
  output frr_stat_t              stat
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);

  logic [ADDR_W-1:0] sector_base;
  logic [ADDR_W-1:0] sector_size;

  // Latched request.
  opcode_t           op;
  logic [3:0]        id;
  logic [ADDR_W-1:0] seg_s;
  logic [ADDR_W-1:0] seg_len;
  logic [ADDR_W:0]   seg_end;
  logic              range_ok;

  logic [MAX_SEGMENTS-1:0] active;
  logic [IDX_W-1:0]        scan_idx;
  logic                    eval_en;
  logic                    eval_act;
  logic [IDX_W-1:0]        eval_idx;
  logic                    conflict;
  logic                    free_found;
  logic [IDX_W-1:0]        free_id;
  logic                    lk_act;

  // Result of the current item, then the output register.
  logic              res_status;
  logic [3:0]        res_id;
  logic [ADDR_W-1:0] res_addr;
  logic [ADDR_W-1:0] res_left;

  logic [ADDR_W-1:0] in_s;
  logic [ADDR_W-1:0] in_len;
  logic [ADDR_W:0]   in_end;
  logic [ADDR_W:0]   sector_end;
  logic              in_range_ok;

  logic              id_ok;
  logic [IDX_W-1:0]  id_idx;
  entry_t            ent;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ADDR_W:0]   ent_end;
  logic              hit;
  logic              reg_ok;

  logic              op_bad;
  logic [ADDR_W-1:0] room;
  logic [ADDR_W-1:0] new_used;
  logic [ADDR_W-1:0] op_addr;
  logic [ADDR_W-1:0] op_left;

  assign in_s        = s_tdata[37:6];
  assign in_len      = s_tdata[69:38];
  assign in_end      = {1'b0, in_s} + {1'b0, in_len};
  assign sector_end  = {1'b0, sector_base} + {1'b0, sector_size};
  assign in_range_ok = (in_len != '0) && (in_len < sector_size) &&
                       (in_s >= sector_base) && (in_end < sector_end);

  assign stat.is_register = (opcode_t'(s_tdata[1:0]) == OP_REGISTER);
  assign stat.scan_last   = (scan_idx == IDX_W'(MAX_SEGMENTS - 1));

  assign id_ok  = (32'(id) < 32'(MAX_SEGMENTS));
  assign id_idx = IDX_W'(id);

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_base <= '0;
      sector_size <= SECTOR_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SECTOR_BASE: sector_base <= cfg_wdata;
        CFG_SECTOR_SIZE: sector_size <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op       <= opcode_t'(s_tdata[1:0]);
      id       <= s_tdata[5:2];
      seg_s    <= in_s;
      seg_len  <= in_len;
      seg_end  <= in_end;
      range_ok <= in_range_ok;
    end
  end

  // Table RAM: the scan reads one entry a cycle, other requests read one entry.
  assign ram_re    = cmd.scan_rd | cmd.lookup_rd;
  assign ram_raddr = cmd.scan_rd ? scan_idx : id_idx;

  frr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ent)
  );

  // Overlap test of the entry read in the previous cycle against the new segment.
  assign ent_end = {1'b0, ent.start} + {1'b0, ent.size};
  always_comb begin
    if (ent.start <= seg_s) begin
      hit = ({1'b0, seg_s} < ent_end);
    end else begin
      hit = (seg_end >= {1'b0, ent.start});
    end
  end

  assign reg_ok = range_ok && !conflict && free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      eval_en    <= 1'b0;
      conflict   <= 1'b0;
      free_found <= 1'b0;
    end else begin
      eval_en <= cmd.scan_rd;
      if (cmd.load_item) begin
        scan_idx   <= '0;
        conflict   <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (eval_en) begin
          if (eval_act && hit) begin
            conflict <= 1'b1;
          end
          if (!eval_act && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      eval_idx <= scan_idx;
      eval_act <= active[scan_idx];
    end
    if (eval_en && !eval_act && !free_found) begin
      free_id <= eval_idx;
    end
    if (cmd.lookup_rd) begin
      lk_act <= id_ok && active[id_idx];
    end
  end

  // Append, read and release on the looked-up entry.
  assign room     = ent.size - ent.used;
  assign new_used = ent.used + seg_len;
  always_comb begin
    op_bad  = !lk_act;
    op_addr = '0;
    op_left = '0;
    case (op)
      OP_APPEND: begin
        op_bad  = !lk_act || (seg_len == '0) || (ent.used > ent.size) || (seg_len > room);
        op_addr = ent.start + ent.used;
        op_left = room - seg_len;
      end
      OP_READ: begin
        op_bad  = !lk_act || (seg_len == '0) || (seg_len > ent.used);
        op_addr = ent.start + ID_BYTES;
        op_left = (ent.size >= ent.used) ? room : '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = id_idx;
    ram_wdata = '{used: new_used, size: ent.size, start: ent.start};
    if (cmd.finish_reg) begin
      ram_we    = reg_ok;
      ram_waddr = free_id;
      ram_wdata = '{used: ID_BYTES, size: seg_len, start: seg_s};
    end else if (cmd.finish_op) begin
      ram_we = (op == OP_APPEND) && !op_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.finish_reg && reg_ok) begin
      active[free_id] <= 1'b1;
    end else if (cmd.finish_op && (op == OP_RELEASE) && !op_bad) begin
      active[id_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_reg) begin
      res_status <= !reg_ok;
      res_id     <= reg_ok ? 4'(free_id) : 4'd0;
      res_addr   <= reg_ok ? seg_s : '0;
      res_left   <= reg_ok ? (seg_len - ID_BYTES) : '0;
    end else if (cmd.finish_op) begin
      res_status <= op_bad;
      res_id     <= 4'd0;
      res_addr   <= op_bad ? '0 : op_addr;
      res_left   <= op_bad ? '0 : op_left;
    end
    if (cmd.out_load) begin
      m_tdata <= {3'b000, res_left, res_addr, res_id, res_status};
    end
  end

  `ASSERT_NEXT(a_reg_sets_active, cmd.finish_reg && reg_ok, active[free_id], "register did not mark its id active")
  `ASSERT_NEXT(a_release_clears, cmd.finish_op && (op == OP_RELEASE) && lk_act, !active[id_idx], "release left its id active")

endmodule

@@ src/frr_ctrl.sv @@
// Controller: sequences the table scan and lookups and owns the stream handshakes.
`include "assert_macros.svh"

module frr_ctrl
  import frr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  frr_stat_t stat,
  output frr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_LOOKUP,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd            = '0;
    cmd.load_item  = accept;
    cmd.scan_rd    = (state == S_SCAN);
    cmd.lookup_rd  = (state == S_LOOKUP);
    cmd.finish_reg = (state == S_DECIDE);
    cmd.finish_op  = (state == S_EXEC);
    cmd.out_load   = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) begin
                  state_next = stat.is_register ? S_SCAN : S_LOOKUP;
                end
      S_SCAN:   if (stat.scan_last) begin
                  state_next = S_DRAIN;
                end
      S_DRAIN:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_DONE;
      S_LOOKUP: state_next = S_EXEC;
      S_EXEC:   state_next = S_DONE;
      S_DONE:   if (out_free) begin
                  state_next = S_IDLE;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.scan_rd, cmd.lookup_rd, cmd.finish_reg, cmd.finish_op, cmd.out_load}), "more than one datapath command at once")
  `ASSERT_NEXT(a_accept_starts, accept, (state == S_SCAN) || (state == S_LOOKUP), "accepted transaction did not start work")

endmodule

@@ src/flash_region_registry.sv @@
// Top level of the flash region registry: segment bookkeeping inside one flash sector.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   opcode, region_id, seg_base, length
//   m_*       out        m_tvalid/m_tready   status, assigned_id, flash_address, bytes_left
//   cfg_*     in         cfg_wr_en           cfg_index, cfg_wdata
//
// A register transaction scans every table entry: the table RAM read port
// checks one entry per cycle for overlap and for the lowest free id.
// Append, read and release make one table read and one update.
// Reset is synchronous and clears the active bits; the table needs no clearing pass.
// A finished result waits in the output register while the next transaction is
// accepted; the controller holds its last step only while that register is still full.
module flash_region_registry
  import frr_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // opcode[1:0], region_id[5:2], seg_base[37:6], length[69:38], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[0], assigned_id[4:1], flash_address[36:5], bytes_left[68:37], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  frr_cmd_t  cmd;
  frr_stat_t stat;

  frr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  frr_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

@@ tb/sv/tb_flash_region_registry.sv @@
// Self-checking testbench for the flash region registry: segment table requests against a predictor.
module tb_flash_region_registry;
  timeunit 1ns;
  timeprecision 1ps;

  import frr_pkg::*;

  localparam int NUM_SEGMENTS = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    opcode_t           op;
    logic [3:0]        rid;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } seg_request_t;

  typedef struct packed {
    logic              status;
    logic [3:0]        id;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] left;
  } seg_answer_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_index = CFG_SECTOR_BASE;
  logic [ADDR_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // opcode[1:0], region_id[5:2], seg_base[37:6], length[69:38], zero pad
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // status[0], assigned_id[4:1], flash_address[36:5], bytes_left[68:37], zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;

  flash_region_registry dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the segment table and sector window.
  bit                seg_on     [NUM_SEGMENTS];
  bit [ADDR_W-1:0]   seg_origin [NUM_SEGMENTS];
  bit [ADDR_W-1:0]   seg_span   [NUM_SEGMENTS];
  bit [ADDR_W-1:0]   seg_fill   [NUM_SEGMENTS];
  bit [ADDR_W-1:0]   sector_first;
  bit [ADDR_W-1:0]   sector_bytes;

  seg_request_t requests_todo[$];
  seg_answer_t  answers_due[$];
  seg_request_t cur_request;
  bit           cur_busy = 1'b0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_go = 1'b0;
  bit           hold_done = 1'b0;
  int           hold_left = 0;
  int           cycles = 0;

  function automatic seg_answer_t apply_request(seg_request_t rq);
    seg_answer_t         ans;
    logic [ADDR_W:0]     s33, e33, end33, as33, ae33;
    logic [ADDR_W-1:0]   size, used;
    bit                  clash;
    int                  k;
    ans = '{status: 1'b1, id: '0, addr: '0, left: '0};
    if (rq.op == OP_REGISTER) begin
      s33   = {1'b0, rq.start};
      e33   = s33 + {1'b0, rq.len};
      end33 = {1'b0, sector_first} + {1'b0, sector_bytes};
      if (rq.len == 0 || rq.len >= sector_bytes || rq.start < sector_first || e33 >= end33)
        return ans;
      clash = 1'b0;
      for (k = 0; k < NUM_SEGMENTS; k++) begin
        if (seg_on[k]) begin
          as33 = {1'b0, seg_origin[k]};
          ae33 = as33 + {1'b0, seg_span[k]};
          // A new segment may not even touch the start of one that follows it.
          if (as33 <= s33) begin
            if (s33 < ae33) clash = 1'b1;
          end else if (e33 >= as33) begin
            clash = 1'b1;
          end
        end
      end
      if (clash) return ans;
      for (k = 0; k < NUM_SEGMENTS; k++) begin
        if (!seg_on[k]) begin
          seg_on[k]     = 1'b1;
          seg_origin[k] = rq.start;
          seg_span[k]   = rq.len;
          seg_fill[k]   = ID_BYTES;
          ans = '{status: 1'b0, id: k[3:0], addr: rq.start, left: rq.len - ID_BYTES};
          return ans;
        end
      end
      return ans;
    end
    if (!seg_on[rq.rid]) return ans;
    size = seg_span[rq.rid];
    used = seg_fill[rq.rid];
    case (rq.op)
      OP_APPEND: begin
        if (rq.len == 0 || used > size || rq.len > size - used) return ans;
        ans.addr = seg_origin[rq.rid] + used;
        used = used + rq.len;
        seg_fill[rq.rid] = used;
        ans.status = 1'b0;
        ans.left = size - used;
      end
      OP_READ: begin
        if (rq.len == 0 || rq.len > used) return ans;
        ans.status = 1'b0;
        ans.addr = seg_origin[rq.rid] + ID_BYTES;
        ans.left = (size >= used) ? size - used : '0;
      end
      default: begin
        seg_on[rq.rid] = 1'b0;
        ans.status = 1'b0;
      end
    endcase
    return ans;
  endfunction

  // Sender: takes the next pending request when free, holds it until the handshake.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!cur_busy) begin
      if (requests_todo.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_request = requests_todo.pop_front();
        cur_busy = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, cur_request.len, cur_request.start, cur_request.rid,
                     cur_request.op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: mirrors configuration writes, checks answers, predicts on every accepted request.
  always @(posedge clk) begin
    seg_answer_t got, want;
    if (rst) begin
      seg_on       = '{default: 1'b0};
      seg_origin   = '{default: '0};
      seg_span     = '{default: '0};
      seg_fill     = '{default: '0};
      sector_first = '0;
      sector_bytes = SECTOR_SIZE_RST;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SECTOR_BASE) sector_first = cfg_wdata;
        else sector_bytes = cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[0];
        got.id     = m_tdata[4:1];
        got.addr   = m_tdata[36:5];
        got.left   = m_tdata[68:37];
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected answer status %0d id %0d addr %h left %h",
                   $time, got.status, got.id, got.addr, got.left);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.id !== want.id ||
              got.addr !== want.addr || got.left !== want.left) begin
            $display("%0t: answer mismatch: expected status %0d id %0d addr %h left %h",
                     $time, want.status, want.id, want.addr, want.left);
            $display("%0t:                  actual   status %0d id %0d addr %h left %h",
                     $time, got.status, got.id, got.addr, got.left);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        answers_due.push_back(apply_request(cur_request));
        cur_busy = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, answers_due.size());
      $display("flash_region_registry regression: fail");
      $finish;
    end
  end

  task automatic push_request(opcode_t op, logic [3:0] rid, logic [ADDR_W-1:0] start,
                              logic [ADDR_W-1:0] len);
    requests_todo.push_back('{op: op, rid: rid, start: start, len: len});
  endtask

  task automatic wait_drained();
    while (requests_todo.size() > 0 || cur_busy || answers_due.size() > 0)
      @(negedge clk);
  endtask

  task automatic set_sector(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SECTOR_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_SECTOR_SIZE;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic clear_table();
    int k;
    for (k = 0; k < NUM_SEGMENTS; k++) push_request(OP_RELEASE, k[3:0], $urandom, $urandom);
  endtask

  // Mostly plausible traffic laid out on a grid of sixteen slots across the sector,
  // so that registrations, fills and reads reach deep into the table.
  task automatic queue_random(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size, int count);
    logic [ADDR_W-1:0] grid, start, len;
    logic [3:0]        rid;
    int                n, pick, slot;
    grid = (size >> 4 == 0) ? 32'd1 : size >> 4;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      rid  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                           4'($urandom_range(0, 7));
      if (pick < 5) begin
        push_request(opcode_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom,
                     $urandom);
      end else if (pick < 35) begin
        slot  = $urandom_range(0, 15);
        start = base + slot * grid + $urandom_range(0, 1);
        if (grid <= 4) len = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0) len = grid;
        else len = $urandom_range(1, grid - grid / 4);
        push_request(OP_REGISTER, rid, start, len);
      end else if (pick < 65) begin
        len = ($urandom_range(0, 19) == 0) ? '0 : $urandom_range(1, (grid >> 3) + 1);
        push_request(OP_APPEND, rid, $urandom, len);
      end else if (pick < 85) begin
        push_request(OP_READ, rid, $urandom, $urandom_range(0, (grid >> 2) + 1));
      end else begin
        push_request(OP_RELEASE, rid, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int k;
    send_idle_pct = 30;
    recv_idle_pct = 86;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default window: bounds, overlap, touching neighbours, fill and read limits.
    set_sector(32'h0, SECTOR_SIZE_RST);
    push_request(OP_REGISTER, 4'd0, 32'h0, 32'h0);
    push_request(OP_REGISTER, 4'd0, 32'h0, SECTOR_SIZE_RST);
    push_request(OP_REGISTER, 4'd0, 32'h100, 32'h100);
    push_request(OP_REGISTER, 4'd0, 32'h180, 32'h10);
    push_request(OP_REGISTER, 4'd0, 32'h200, 32'h100);
    push_request(OP_REGISTER, 4'd0, 32'hF0, 32'h10);
    push_request(OP_REGISTER, 4'd0, 32'h1FF00, 32'h100);
    push_request(OP_REGISTER, 4'd0, 32'h1FF00, 32'hFF);
    push_request(OP_APPEND, 4'd0, 32'h0, 32'h0);
    push_request(OP_APPEND, 4'd0, 32'hFFFF_FFFF, 32'hFF);
    push_request(OP_APPEND, 4'd0, 32'h0, 32'h1);
    push_request(OP_READ, 4'd0, 32'h0, 32'h100);
    push_request(OP_READ, 4'd0, 32'h0, 32'h101);
    push_request(OP_READ, 4'd1, 32'h0, 32'h0);
    push_request(OP_APPEND, 4'd15, 32'h0, 32'hFFFF_FFFF);
    push_request(OP_RELEASE, 4'd1, 32'h0, 32'h0);
    push_request(OP_RELEASE, 4'd1, 32'h0, 32'h0);
    push_request(OP_READ, 4'd1, 32'h0, 32'h1);
    push_request(OP_REGISTER, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(OP_REGISTER, 4'd15, 32'h200, 32'h80);
    queue_random(32'h0, SECTOR_SIZE_RST, 250);

    // A zero-sized sector turns every registration away.
    set_sector($urandom, 32'h0);
    clear_table();
    queue_random(32'h0, 32'h100, 20);

    // Widest window at the top of the address space: addresses wrap past zero.
    set_sector(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_idle_pct = 86;
    recv_idle_pct = 30;
    clear_table();
    push_request(OP_REGISTER, 4'd0, 32'h0, 32'h1);
    push_request(OP_REGISTER, 4'd0, 32'hFFFF_FFFF, 32'h10);
    push_request(OP_APPEND, 4'd0, 32'h0, 32'h4);
    push_request(OP_READ, 4'd0, 32'h0, 32'h1);
    queue_random(32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);

    // Tiny window: sixteen one-byte segments fill the table and the next one is refused.
    set_sector(32'h1000, 32'd40);
    clear_table();
    for (k = 0; k <= NUM_SEGMENTS; k++) push_request(OP_REGISTER, 4'd0, 32'h1000 + 2 * k, 32'h1);
    queue_random(32'h1000, 32'd40, 150);

    // Full rate both sides, with one long receiver hold-off to back the block up.
    set_sector($urandom_range(0, 32'hF000_0000), 32'h0010_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_table();
    queue_random(sector_first, sector_bytes, 250);
    hold_go = 1'b1;

    wait_drained();
    repeat (4 * (NUM_SEGMENTS + 4)) @(negedge clk);
    if (mismatches == 0) begin
      $display("flash_region_registry regression: pass");
    end else begin
      $display("flash_region_registry regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/frr_pkg.sv
src/frr_ram.sv
src/frr_datapath.sv
src/frr_ctrl.sv
src/flash_region_registry.sv
tb/sv/tb_flash_region_registry.sv
